// File: src/mrtu_pkg.sv
// Package: types, constants and the CRC and length functions of the Modbus RTU frame checker.
`default_nettype none

package mrtu_pkg;

  // Result status codes
  typedef enum logic [2:0] {
    ST_TOO_SHORT  = 3'd0,
    ST_OTHER_ADDR = 3'd1,
    ST_INCOMPLETE = 3'd2,
    ST_UNKNOWN_FC = 3'd3,
    ST_CRC_ERROR  = 3'd4,
    ST_VALID      = 3'd5
  } status_t;

  typedef struct packed {
    status_t     status;
    logic [7:0]  function_code;
    logic [8:0]  frame_length;
  } result_t;

  // Register indexes on the configuration port (address bit 2)
  localparam logic REG_DEVICE_ADDRESS   = 1'b0;
  localparam logic REG_CHECKS_RESPONSES = 1'b1;

  localparam logic [7:0] DEVICE_ADDRESS_RST = 8'h01;
  localparam logic       CHECKS_RESPONSES_RST = 1'b1;

  // Function codes
  localparam logic [7:0] FC_READ_COILS        = 8'h01;
  localparam logic [7:0] FC_READ_HOLDING      = 8'h03;
  localparam logic [7:0] FC_READ_INPUT        = 8'h04;
  localparam logic [7:0] FC_WRITE_COIL        = 8'h05;
  localparam logic [7:0] FC_WRITE_REG         = 8'h06;
  localparam logic [7:0] FC_WRITE_MULTI_COILS = 8'h0F;
  localparam logic [7:0] FC_WRITE_MULTI_REGS  = 8'h10;
  localparam logic [7:0] FC_EXCEPTION_BASE    = 8'h80;

  // Expected length codes and values
  localparam logic [8:0] LEN_PENDING    = 9'd0;
  localparam logic [8:0] LEN_UNKNOWN    = 9'd1;
  localparam logic [8:0] LEN_MIN_FRAME  = 9'd4;
  localparam logic [8:0] LEN_SHORT_RESP = 9'd5;
  localparam logic [8:0] LEN_FIXED      = 9'd8;
  localparam logic [8:0] LEN_MULTI_BASE = 9'd9;

  // Byte positions of the function code and the count bytes, and the byte count ceiling
  localparam logic [8:0] POS_FUNCTION   = 9'd1;
  localparam logic [8:0] POS_RESP_COUNT = 9'd2;
  localparam logic [8:0] POS_REQ_COUNT  = 9'd6;
  localparam logic [8:0] COUNT_MAX      = 9'd511;

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;

  // One byte of reflected CRC-16, bit by bit
  function automatic logic [15:0] crc16_byte(input logic [15:0] crc_in, input logic [7:0] b);
    logic [15:0] c;
    c = crc_in ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

  // Length class from the function code: fixed length, pending, or unknown
  function automatic logic [8:0] classify(input logic [7:0] fc, input logic responses);
    logic [8:0] len;
    len = LEN_UNKNOWN;
    if (responses) begin
      if (fc == FC_READ_COILS) begin
        len = LEN_PENDING;
      end else if (fc == FC_WRITE_COIL || fc == FC_WRITE_MULTI_COILS) begin
        len = LEN_FIXED;
      end else if (fc > FC_EXCEPTION_BASE) begin
        len = LEN_SHORT_RESP;
      end
    end else begin
      if (fc == FC_READ_COILS || fc == FC_READ_HOLDING ||
          fc == FC_READ_INPUT || fc == FC_WRITE_REG) begin
        len = LEN_FIXED;
      end else if (fc == FC_WRITE_MULTI_REGS) begin
        len = LEN_PENDING;
      end
    end
    return len;
  endfunction

endpackage

`default_nettype wire

// File: src/mrtu_if.sv
// Interfaces: the byte input channel and the result channel.
`default_nettype none

interface mrtu_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

interface mrtu_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] status;
  logic [7:0] function_code;
  logic [8:0] frame_length;

  modport source (output valid, output status, output function_code, output frame_length,
                  input ready);
  modport sink (input valid, input status, input function_code, input frame_length,
                output ready);
endinterface

`default_nettype wire

// File: src/modbus_rtu_frame_checker.sv
// Top level of the Modbus RTU frame checker: input register, frame state, result register, APB.
`default_nettype none

// Modbus RTU frame checker. Feed the bytes of one received buffer on byte_ch, one item per
// byte, and set last_byte on the final byte; that item, and only that one, yields one
// result item on result_ch: status (too short, other address, incomplete, unknown function,
// CRC error, valid), the function code and the expected frame length. The expected length
// comes from the function code and the role (checks_responses = 1 checks master-side
// responses, 0 checks slave-side requests); the CRC-16 (polynomial 0xA001 reflected, seed
// 0xFFFF) runs over the frame minus its last two bytes and is compared low byte first.
// Bytes past the expected length are ignored. Throughput is one byte per clock unless
// byte_ch stalls: each byte is held in the input register, then the byte-wide CRC update
// and the length and status logic settle combinationally into the frame state and the
// result register, which loads a result as its last byte leaves the input register. byte_ch
// stalls only when a last byte must wait for the result register because an earlier
// result has not been taken. Configuration registers: device_address at 0x0 (reset 1),
// checks_responses at 0x4 (reset 1); write them only while no buffer is in progress.
module modbus_rtu_frame_checker (
  input  wire logic         clk,
  input  wire logic         rst,
  mrtu_in_if.sink           byte_ch,
  mrtu_out_if.source        result_ch,
  input  wire logic         psel,
  input  wire logic         penable,
  input  wire logic         pwrite,
  input  wire logic [2:0]   paddr,
  input  wire logic [31:0]  pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  // Configuration registers
  logic [7:0] device_address;
  logic       checks_responses;

  // Input register
  logic       s1_valid;
  logic [7:0] s1_byte;
  logic       s1_last;
  logic       s1_adv;

  // Result register
  logic              res_valid;
  mrtu_pkg::result_t res;
  mrtu_pkg::result_t core_result;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      device_address   <= mrtu_pkg::DEVICE_ADDRESS_RST;
      checks_responses <= mrtu_pkg::CHECKS_RESPONSES_RST;
    end else if (psel && penable && pwrite && pready) begin
      case (paddr[2])
        mrtu_pkg::REG_DEVICE_ADDRESS:   device_address   <= pwdata[7:0];
        mrtu_pkg::REG_CHECKS_RESPONSES: checks_responses <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      mrtu_pkg::REG_DEVICE_ADDRESS:   prdata = {24'h000000, device_address};
      mrtu_pkg::REG_CHECKS_RESPONSES: prdata = {31'h00000000, checks_responses};
      default:                        prdata = 32'h00000000;
    endcase
  end

  // Advance the held byte unless it is a last byte and the result slot is still full
  assign s1_adv        = s1_valid && (!s1_last || !res_valid || result_ch.ready);
  assign byte_ch.ready = !s1_valid || s1_adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (byte_ch.ready) begin
      s1_valid <= byte_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (byte_ch.valid && byte_ch.ready) begin
      s1_byte <= byte_ch.data_byte;
      s1_last <= byte_ch.last_byte;
    end
  end

  mrtu_frame_core u_core (
    .clk              (clk),
    .rst              (rst),
    .step             (s1_adv),
    .data_byte        (s1_byte),
    .last_byte        (s1_last),
    .device_address   (device_address),
    .checks_responses (checks_responses),
    .result           (core_result)
  );

  // Load the result on a last byte; drop it once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (s1_adv && s1_last) begin
      res_valid <= 1'b1;
    end else if (result_ch.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1_last) begin
      res <= core_result;
    end
  end

  assign result_ch.valid         = res_valid;
  assign result_ch.status        = res.status;
  assign result_ch.function_code = res.function_code;
  assign result_ch.frame_length  = res.frame_length;

endmodule

`default_nettype wire

// File: src/mrtu_frame_core.sv
// Frame state: address, function, expected length, running CRC and the result of a buffer.
`default_nettype none

module mrtu_frame_core (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             step,
  input  wire logic [7:0]       data_byte,
  input  wire logic             last_byte,
  input  wire logic [7:0]       device_address,
  input  wire logic             checks_responses,
  output mrtu_pkg::result_t     result
);

  logic [8:0]  byte_count;
  logic [15:0] crc_register;
  logic [7:0]  first_byte;
  logic [7:0]  function_byte;
  logic [8:0]  expected_length;
  logic [15:0] received_crc;

  logic [8:0]  byte_count_next;
  logic [15:0] crc_register_next;
  logic [7:0]  first_byte_next;
  logic [7:0]  function_byte_next;
  logic [8:0]  expected_length_next;
  logic [15:0] received_crc_next;

  logic [8:0]  len_class;
  logic        len_known;

  always_comb begin
    first_byte_next    = (byte_count == 9'd0) ? data_byte : first_byte;
    function_byte_next = (byte_count == mrtu_pkg::POS_FUNCTION) ? data_byte : function_byte;

    len_class = (byte_count == mrtu_pkg::POS_FUNCTION)
              ? mrtu_pkg::classify(data_byte, checks_responses) : expected_length;

    // Resolve a pending length from its count byte
    expected_length_next = len_class;
    if (byte_count == mrtu_pkg::POS_RESP_COUNT && len_class == mrtu_pkg::LEN_PENDING &&
        checks_responses && function_byte_next == mrtu_pkg::FC_READ_COILS) begin
      expected_length_next = mrtu_pkg::LEN_SHORT_RESP + {1'b0, data_byte};
    end else if (byte_count == mrtu_pkg::POS_REQ_COUNT &&
                 len_class == mrtu_pkg::LEN_PENDING && !checks_responses &&
                 function_byte_next == mrtu_pkg::FC_WRITE_MULTI_REGS) begin
      expected_length_next = mrtu_pkg::LEN_MULTI_BASE + {1'b0, data_byte};
    end

    len_known = (expected_length_next >= mrtu_pkg::LEN_MIN_FRAME);

    // CRC covers everything before the two check bytes
    if (expected_length_next == mrtu_pkg::LEN_PENDING ||
        (len_known && byte_count < expected_length_next - 9'd2)) begin
      crc_register_next = mrtu_pkg::crc16_byte(crc_register, data_byte);
    end else begin
      crc_register_next = crc_register;
    end

    received_crc_next = received_crc;
    if (len_known) begin
      if (byte_count == expected_length_next - 9'd2) begin
        received_crc_next = {received_crc[15:8], data_byte};
      end else if (byte_count == expected_length_next - 9'd1) begin
        received_crc_next = {data_byte, received_crc[7:0]};
      end
    end

    byte_count_next = (byte_count == mrtu_pkg::COUNT_MAX) ? mrtu_pkg::COUNT_MAX
                    : byte_count + 9'd1;

    // Status, in order of precedence
    result.frame_length  = 9'd0;
    result.function_code = (byte_count_next >= 9'd2) ? function_byte_next : 8'h00;
    if (byte_count_next < 9'd2) begin
      result.status = mrtu_pkg::ST_TOO_SHORT;
    end else if (first_byte_next != device_address) begin
      result.status = mrtu_pkg::ST_OTHER_ADDR;
    end else if (expected_length_next == mrtu_pkg::LEN_UNKNOWN) begin
      result.status = mrtu_pkg::ST_UNKNOWN_FC;
    end else if (expected_length_next == mrtu_pkg::LEN_PENDING) begin
      result.status = mrtu_pkg::ST_INCOMPLETE;
    end else begin
      result.frame_length = expected_length_next;
      if (expected_length_next > byte_count_next) begin
        result.status = mrtu_pkg::ST_INCOMPLETE;
      end else if (crc_register_next == received_crc_next) begin
        result.status = mrtu_pkg::ST_VALID;
      end else begin
        result.status = mrtu_pkg::ST_CRC_ERROR;
      end
    end
  end

  // Clear all buffer state after the last byte
  always_ff @(posedge clk) begin
    if (rst || (step && last_byte)) begin
      byte_count      <= 9'd0;
      crc_register    <= mrtu_pkg::CRC_INIT;
      first_byte      <= 8'h00;
      function_byte   <= 8'h00;
      expected_length <= mrtu_pkg::LEN_PENDING;
      received_crc    <= 16'h0000;
    end else if (step) begin
      byte_count      <= byte_count_next;
      crc_register    <= crc_register_next;
      first_byte      <= first_byte_next;
      function_byte   <= function_byte_next;
      expected_length <= expected_length_next;
      received_crc    <= received_crc_next;
    end
  end

endmodule

`default_nettype wire

// File: src/mrtu_checker.sv
// Port checker for the Modbus RTU frame checker and its bind to the top level.
`default_nettype none

module mrtu_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       res_valid,
  input wire logic       res_ready,
  input wire logic [2:0] status,
  input wire logic [7:0] function_code,
  input wire logic [8:0] frame_length
);

  // A waiting result holds
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(status) &&
    $stable(function_code) && $stable(frame_length))
    else $error("result changed while stalled");

  a_status_range: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> status <= mrtu_pkg::ST_VALID)
    else $error("status code out of range");

  a_len_zero: assert property (@(posedge clk) disable iff (rst)
    res_valid && (status == mrtu_pkg::ST_TOO_SHORT || status == mrtu_pkg::ST_OTHER_ADDR ||
                  status == mrtu_pkg::ST_UNKNOWN_FC) |-> frame_length == 9'd0)
    else $error("frame length reported without a known length");

  a_short_no_fc: assert property (@(posedge clk) disable iff (rst)
    res_valid && status == mrtu_pkg::ST_TOO_SHORT |-> function_code == 8'h00)
    else $error("function code reported for a short buffer");

  a_valid_len: assert property (@(posedge clk) disable iff (rst)
    res_valid && (status == mrtu_pkg::ST_VALID || status == mrtu_pkg::ST_CRC_ERROR) |->
    frame_length >= mrtu_pkg::LEN_SHORT_RESP && frame_length <= 9'd264)
    else $error("checked frame with impossible length");

endmodule

bind modbus_rtu_frame_checker mrtu_checker u_mrtu_checker (
  .clk           (clk),
  .rst           (rst),
  .res_valid     (result_ch.valid),
  .res_ready     (result_ch.ready),
  .status        (result_ch.status),
  .function_code (result_ch.function_code),
  .frame_length  (result_ch.frame_length)
);

`default_nettype wire

// File: bench/modbus_rtu_frame_checker_tb.sv
// Self-checking testbench of the Modbus RTU frame checker: byte stream in, verdicts out.
`timescale 1ns / 100ps

module modbus_rtu_frame_checker_tb;

  localparam int CYCLE_LIMIT = 200000;
  localparam int PHASE_ITEMS = 20;
  localparam int LONG_BUFFER = 514;

  // Tracks the frame state of the block byte by byte and keeps the verdicts still due.
  class frame_checker_model;
    logic [7:0]  dev_addr;
    logic        resp_role;
    logic [8:0]  count;
    logic [15:0] crc;
    logic [7:0]  addr_byte;
    logic [7:0]  fc_byte;
    logic [8:0]  exp_len;
    logic [15:0] rx_crc;
    mrtu_pkg::result_t verdicts_due[$];
    int          mismatches;

    function new();
      dev_addr = mrtu_pkg::DEVICE_ADDRESS_RST;
      resp_role = mrtu_pkg::CHECKS_RESPONSES_RST;
      mismatches = 0;
      clear();
    endfunction

    function void clear();
      count = '0;
      crc = mrtu_pkg::CRC_INIT;
      addr_byte = '0;
      fc_byte = '0;
      exp_len = mrtu_pkg::LEN_PENDING;
      rx_crc = '0;
    endfunction

    // Reflected CRC-16, one byte, shift by shift.
    static function logic [15:0] crc16_step(logic [15:0] c, logic [7:0] b);
      logic [15:0] r;
      r = c ^ {8'h00, b};
      repeat (8) r = (r >> 1) ^ (r[0] ? mrtu_pkg::CRC_POLY : 16'h0000);
      return r;
    endfunction

    function logic [8:0] length_from_code(logic [7:0] fc);
      if (resp_role) begin
        case (fc)
          mrtu_pkg::FC_READ_COILS: return mrtu_pkg::LEN_PENDING;
          mrtu_pkg::FC_WRITE_COIL, mrtu_pkg::FC_WRITE_MULTI_COILS: return mrtu_pkg::LEN_FIXED;
          default: return (fc > mrtu_pkg::FC_EXCEPTION_BASE) ? mrtu_pkg::LEN_SHORT_RESP
                                                             : mrtu_pkg::LEN_UNKNOWN;
        endcase
      end
      case (fc)
        mrtu_pkg::FC_READ_COILS, mrtu_pkg::FC_READ_HOLDING, mrtu_pkg::FC_READ_INPUT,
        mrtu_pkg::FC_WRITE_REG: return mrtu_pkg::LEN_FIXED;
        mrtu_pkg::FC_WRITE_MULTI_REGS: return mrtu_pkg::LEN_PENDING;
        default: return mrtu_pkg::LEN_UNKNOWN;
      endcase
    endfunction

    function void take_byte(logic [7:0] b, logic last);
      int                idx;
      mrtu_pkg::result_t v;
      idx = count;
      if (idx == 0) addr_byte = b;
      if (idx == 1) begin
        fc_byte = b;
        exp_len = length_from_code(b);
      end
      if (idx == 2 && exp_len == mrtu_pkg::LEN_PENDING && resp_role &&
          fc_byte == mrtu_pkg::FC_READ_COILS)
        exp_len = mrtu_pkg::LEN_SHORT_RESP + b;
      if (idx == 6 && exp_len == mrtu_pkg::LEN_PENDING && !resp_role &&
          fc_byte == mrtu_pkg::FC_WRITE_MULTI_REGS)
        exp_len = mrtu_pkg::LEN_MULTI_BASE + b;
      if (exp_len == mrtu_pkg::LEN_PENDING ||
          (exp_len >= mrtu_pkg::LEN_MIN_FRAME && idx < exp_len - 2))
        crc = crc16_step(crc, b);
      if (exp_len >= mrtu_pkg::LEN_MIN_FRAME) begin
        if (idx == exp_len - 2) rx_crc[7:0] = b;
        else if (idx == exp_len - 1) rx_crc[15:8] = b;
      end
      count = (idx < mrtu_pkg::COUNT_MAX) ? 9'(idx + 1) : mrtu_pkg::COUNT_MAX;
      if (!last) return;
      v.function_code = (count >= 2) ? fc_byte : 8'h00;
      v.frame_length = '0;
      if (count < 2) v.status = mrtu_pkg::ST_TOO_SHORT;
      else if (addr_byte != dev_addr) v.status = mrtu_pkg::ST_OTHER_ADDR;
      else if (exp_len == mrtu_pkg::LEN_UNKNOWN) v.status = mrtu_pkg::ST_UNKNOWN_FC;
      else if (exp_len == mrtu_pkg::LEN_PENDING) v.status = mrtu_pkg::ST_INCOMPLETE;
      else begin
        v.frame_length = exp_len;
        if (exp_len > count) v.status = mrtu_pkg::ST_INCOMPLETE;
        else if (crc == rx_crc) v.status = mrtu_pkg::ST_VALID;
        else v.status = mrtu_pkg::ST_CRC_ERROR;
      end
      verdicts_due.push_back(v);
      clear();
    endfunction

    function void check_verdict(logic [2:0] st, logic [7:0] fc, logic [8:0] flen);
      mrtu_pkg::result_t v;
      if (verdicts_due.size() == 0) begin
        $error("result with no buffer pending: status %0d", st);
        mismatches++;
        return;
      end
      v = verdicts_due.pop_front();
      if (st !== v.status) begin
        $error("status: expected %0d, actual %0d", v.status, st);
        mismatches++;
      end
      if (fc !== v.function_code) begin
        $error("function_code: expected 0x%02h, actual 0x%02h", v.function_code, fc);
        mismatches++;
      end
      if (flen !== v.frame_length) begin
        $error("frame_length: expected %0d, actual %0d", v.frame_length, flen);
        mismatches++;
      end
    endfunction

    function int pending();
      return verdicts_due.size();
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  mrtu_in_if  byte_ch ();
  mrtu_out_if result_ch ();

  frame_checker_model model;
  logic [7:0]         frame_bytes[$];
  bit                 quiet;
  int                 sent_items;
  int                 cycle_count;

  modbus_rtu_frame_checker dut (
    .clk       (clk),
    .rst       (rst),
    .byte_ch   (byte_ch),
    .result_ch (result_ch),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Abort a hung run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("modbus_rtu_frame_checker_tb: FAIL");
      $finish;
    end
  end

  // Hold the result side's ready low about 8 percent of the time, except in quiet phases.
  always @(negedge clk) begin
    result_ch.ready <= quiet || ($urandom_range(99) >= 8);
  end

  // Feed every accepted byte to the model and check every accepted result.
  always @(posedge clk) begin
    if (!rst) begin
      if (byte_ch.valid && byte_ch.ready)
        model.take_byte(byte_ch.data_byte, byte_ch.last_byte);
      if (result_ch.valid && result_ch.ready)
        model.check_verdict(result_ch.status, result_ch.function_code,
                            result_ch.frame_length);
    end
  end

  // Offer one byte; enter and leave at a falling edge. Valid stays high on return so
  // back-to-back items need no gap.
  task automatic send_byte(input logic [7:0] b, input logic last);
    while (!quiet && $urandom_range(99) < 8) begin
      byte_ch.valid <= 1'b0;
      @(negedge clk);
    end
    byte_ch.valid <= 1'b1;
    byte_ch.data_byte <= b;
    byte_ch.last_byte <= last;
    do @(posedge clk); while (!byte_ch.ready);
    sent_items++;
    @(negedge clk);
  endtask

  task automatic send_frame();
    foreach (frame_bytes[i]) send_byte(frame_bytes[i], i == frame_bytes.size() - 1);
  endtask

  // Append the CRC of the bytes so far, low byte first.
  task automatic append_crc();
    logic [15:0] c;
    c = mrtu_pkg::CRC_INIT;
    foreach (frame_bytes[i]) c = frame_checker_model::crc16_step(c, frame_bytes[i]);
    frame_bytes.push_back(c[7:0]);
    frame_bytes.push_back(c[15:8]);
  endtask

  // Drop valid and hold until every verdict has come back.
  task automatic drain();
    byte_ch.valid <= 1'b0;
    while (model.pending() != 0) @(negedge clk);
  endtask

  // APB write: setup cycle, then access cycle until pready.
  task automatic write_reg(input logic idx, input logic [31:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (idx == mrtu_pkg::REG_DEVICE_ADDRESS) model.dev_addr = value[7:0];
    else model.resp_role = value[0];
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  // Mostly small counts, now and then a near-full data block.
  function automatic int pick_count();
    return ($urandom_range(29) == 0) ? $urandom_range(200, 255) : $urandom_range(0, 6);
  endfunction

  // Build one buffer: mostly a well-formed frame for the current role and address,
  // sometimes corrupted, cut short or padded; otherwise plain noise.
  task automatic build_random_frame();
    int         n;
    int         k;
    logic [7:0] fc;
    frame_bytes.delete();
    if ($urandom_range(99) < 80) begin
      frame_bytes.push_back(($urandom_range(9) == 0) ? 8'($urandom) : model.dev_addr);
      if (model.resp_role) begin
        case ($urandom_range(3))
          0: fc = mrtu_pkg::FC_READ_COILS;
          1: fc = mrtu_pkg::FC_WRITE_COIL;
          2: fc = mrtu_pkg::FC_WRITE_MULTI_COILS;
          default: fc = 8'($urandom_range(mrtu_pkg::FC_EXCEPTION_BASE + 1, 8'hFF));
        endcase
      end else begin
        case ($urandom_range(4))
          0: fc = mrtu_pkg::FC_READ_COILS;
          1: fc = mrtu_pkg::FC_READ_HOLDING;
          2: fc = mrtu_pkg::FC_READ_INPUT;
          3: fc = mrtu_pkg::FC_WRITE_REG;
          default: fc = mrtu_pkg::FC_WRITE_MULTI_REGS;
        endcase
      end
      frame_bytes.push_back(fc);
      if (model.resp_role && fc == mrtu_pkg::FC_READ_COILS) begin
        n = pick_count();
        frame_bytes.push_back(8'(n));
        repeat (n) frame_bytes.push_back(8'($urandom));
      end else if (model.resp_role && fc > mrtu_pkg::FC_EXCEPTION_BASE) begin
        frame_bytes.push_back(8'($urandom));
      end else begin
        repeat (4) frame_bytes.push_back(8'($urandom));
        if (!model.resp_role && fc == mrtu_pkg::FC_WRITE_MULTI_REGS) begin
          n = pick_count();
          frame_bytes.push_back(8'(n));
          repeat (n) frame_bytes.push_back(8'($urandom));
        end
      end
      append_crc();
      // Flip one bit somewhere in about one frame of ten.
      if ($urandom_range(9) == 0) begin
        k = $urandom_range(frame_bytes.size() - 1);
        frame_bytes[k] = frame_bytes[k] ^ 8'(1 << $urandom_range(7));
      end
      case ($urandom_range(9))
        0: begin
          n = $urandom_range(1, frame_bytes.size() - 1);
          while (frame_bytes.size() > n) void'(frame_bytes.pop_back());
        end
        1: repeat ($urandom_range(1, 3)) frame_bytes.push_back(8'($urandom));
        default: ;
      endcase
    end else begin
      n = $urandom_range(1, 12);
      repeat (n) frame_bytes.push_back(8'($urandom));
      if ($urandom_range(1) == 1) frame_bytes[0] = model.dev_addr;
    end
  endtask

  initial begin
    logic [7:0] addr;
    logic       role;
    bit         paused;
    model = new();
    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    byte_ch.valid = 1'b0;
    byte_ch.data_byte = '0;
    byte_ch.last_byte = 1'b0;
    quiet = 1'b0;
    paused = 1'b0;
    repeat (8) @(negedge clk);
    rst <= 1'b0;

    // Directed buffers under the reset settings (address 1, response role).
    // A lone byte is too short.
    frame_bytes = '{8'h01};
    send_frame();
    // Wrong address.
    frame_bytes = '{8'h02, 8'h03};
    send_frame();
    // Function code zero and exactly the exception base are unknown.
    frame_bytes = '{8'h01, 8'h00};
    send_frame();
    frame_bytes = '{8'h01, mrtu_pkg::FC_EXCEPTION_BASE};
    send_frame();
    // Read coils cut before its count byte: length never known.
    frame_bytes = '{8'h01, mrtu_pkg::FC_READ_COILS};
    send_frame();
    // Good exception reply with the top code.
    frame_bytes = '{8'h01, 8'hFF, 8'h00};
    append_crc();
    send_frame();
    // Exception reply with a broken CRC high byte.
    frame_bytes = '{8'h01, mrtu_pkg::FC_EXCEPTION_BASE + 8'h01, 8'hFF};
    append_crc();
    frame_bytes[4] = frame_bytes[4] ^ 8'h80;
    send_frame();
    // Read coils reply with an empty data block.
    frame_bytes = '{8'h01, mrtu_pkg::FC_READ_COILS, 8'h00};
    append_crc();
    send_frame();

    // Random phases, each under new settings; extremes first.
    for (int p = 0; p < 5; p++) begin
      case (p)
        0: begin
          addr = 8'h00;
          role = 1'b0;
        end
        1: begin
          addr = 8'hFF;
          role = 1'b1;
        end
        default: begin
          addr = 8'($urandom);
          role = 1'($urandom_range(1));
        end
      endcase
      // Let the last buffer settle before touching the registers.
      drain();
      repeat (4) @(negedge clk);
      write_reg(mrtu_pkg::REG_DEVICE_ADDRESS, {24'h0, addr});
      write_reg(mrtu_pkg::REG_CHECKS_RESPONSES, {31'h0, role});
      quiet = (p == 1);
      sent_items = 0;
      while (sent_items < PHASE_ITEMS) begin
        // Once, halfway through a phase, starve the block until it has answered all.
        if (p == 2 && !paused && sent_items >= PHASE_ITEMS / 2) begin
          drain();
          paused = 1'b1;
        end
        build_random_frame();
        send_frame();
      end
      // A long buffer with no idling drives the byte count into saturation.
      if (p == 1) begin
        frame_bytes.delete();
        frame_bytes.push_back(model.dev_addr);
        frame_bytes.push_back(mrtu_pkg::FC_READ_COILS);
        repeat (LONG_BUFFER - 2) frame_bytes.push_back(8'($urandom));
        send_frame();
      end
    end

    drain();
    repeat (8) @(negedge clk);
    if (model.mismatches == 0 && model.pending() == 0) begin
      $display("modbus_rtu_frame_checker_tb: PASS");
    end else begin
      $display("modbus_rtu_frame_checker_tb: FAIL");
    end
    $finish;
  end

endmodule
